@@ rtl/core/dvrt_pkg.sv @@
// Shared types, constants and helpers for the distance-vector route table.
package dvrt_pkg;

   localparam int NODES      = 8;
   localparam int NODE_W     = 3;
   localparam int COST_W     = 16;
   localparam int MISS_W     = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   localparam logic [COST_W-1:0] INF_COST = 16'hFFFF;
   localparam logic [MISS_W-1:0] MISS_MAX = 4'hF;

   localparam logic [NODE_W-1:0] SELF_ID_RESET    = 3'd0;
   localparam logic [MISS_W-1:0] MISS_LIMIT_RESET = 4'd3;

   typedef enum logic [1:0] {
      KIND_VECTOR = 2'd0,
      KIND_TICK   = 2'd1,
      KIND_LINK   = 2'd2,
      KIND_QUERY  = 2'd3
   } kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SELF_ID    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MISS_LIMIT = 1'b1;

   // one row of the table: route plus per-neighbor bookkeeping
   typedef struct packed {
      logic [COST_W-1:0] route_cost;
      logic [NODE_W-1:0] hop;
      logic              hop_valid;
      logic [COST_W-1:0] link_cost;
      logic              neighbor;
      logic              heard;
      logic [MISS_W-1:0] miss;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      route_cost: INF_COST,
      hop:        '0,
      hop_valid:  1'b0,
      link_cost:  INF_COST,
      neighbor:   1'b0,
      heard:      1'b0,
      miss:       '0
   };

   typedef struct packed {
      logic [NODE_W-1:0] dest_node;
      logic [NODE_W-1:0] next_hop;
      logic [COST_W-1:0] route_cost;
      logic              reachable;
      logic              is_local;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [COST_W-1:0] sum;
      logic              less;
   } alu_res_type;

   function automatic logic in_range(input logic [NODE_W-1:0] idx);
      return 32'(idx) < NODES;
   endfunction

   // Build the result for one destination from its stored row.
   function automatic rsp_type emit(input entry_type ent,
                                    input logic [NODE_W-1:0] idx,
                                    input logic [NODE_W-1:0] self_id,
                                    input logic last);
      rsp_type r;
      r.dest_node  = idx;
      r.next_hop   = '0;
      r.route_cost = INF_COST;
      r.reachable  = 1'b0;
      r.is_local   = (idx == self_id);
      r.last       = last;
      if (in_range(idx)) begin
         if (idx == self_id) begin
            r.route_cost = '0;
            r.next_hop   = self_id;
            r.reachable  = 1'b1;
         end else begin
            r.route_cost = ent.route_cost;
            if (ent.hop_valid && ent.route_cost != INF_COST) begin
               r.reachable = 1'b1;
               r.next_hop  = ent.hop;
            end
         end
      end
      return r;
   endfunction

endpackage

@@ rtl/core/dvrt_alu.sv @@
// Saturating cost adder with strict less-than compare.
module dvrt_alu (
   input  logic [dvrt_pkg::COST_W-1:0] op_a,
   input  logic [dvrt_pkg::COST_W-1:0] op_b,
   input  logic [dvrt_pkg::COST_W-1:0] op_limit,
   output dvrt_pkg::alu_res_type       res
);

   logic [dvrt_pkg::COST_W:0]   raw_sum;
   logic [dvrt_pkg::COST_W-1:0] sat_sum;

   always_comb begin
      raw_sum  = {1'b0, op_a} + {1'b0, op_b};
      sat_sum  = raw_sum[dvrt_pkg::COST_W] ? dvrt_pkg::INF_COST
                                          : raw_sum[dvrt_pkg::COST_W-1:0];
      res.sum  = sat_sum;
      res.less = sat_sum < op_limit;
   end

endmodule

@@ rtl/core/dvrt_table.sv @@
// Per-node route table storage: one read index and one row write per cycle.
module dvrt_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [dvrt_pkg::NODE_W-1:0] rd_idx,
   output dvrt_pkg::entry_type         rd_ent,
   input  logic                        wr_en,
   input  logic [dvrt_pkg::NODE_W-1:0] wr_idx,
   input  dvrt_pkg::entry_type         wr_ent
);

   dvrt_pkg::entry_type ent_ff [dvrt_pkg::NODES];
   dvrt_pkg::entry_type ent_in [dvrt_pkg::NODES];

   always_comb begin
      ent_in = ent_ff;
      if (wr_en) begin
         ent_in[wr_idx] = wr_ent;
      end
   end

   assign rd_ent = ent_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dvrt_pkg::NODES; i++) begin
            ent_ff[i] <= dvrt_pkg::ENTRY_RESET;
         end
      end else begin
         ent_ff <= ent_in;
      end
   end

endmodule

@@ rtl/core/distance_vector_route_table.sv @@
// Distance-vector route table top level: sequencer, config registers, result register.
// Vector entry: sender row state, then destination relax state (sender row only when
// the destination is this node). Link cost: link state. Query: the result is
// registered once the result register is free. Tick: NODES results, one table row a
// cycle while the result is not stalled, aged as it is dumped. Next request is taken
// once back in idle. Synchronous reset clears the whole table; no clearing pass.
module distance_vector_route_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_kind,
   input  logic [dvrt_pkg::NODE_W-1:0]     req_node,
   input  logic [dvrt_pkg::NODE_W-1:0]     req_dest,
   input  logic [dvrt_pkg::COST_W-1:0]     req_cost,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [dvrt_pkg::NODE_W-1:0]     rsp_dest_node,
   output logic [dvrt_pkg::NODE_W-1:0]     rsp_next_hop,
   output logic [dvrt_pkg::COST_W-1:0]     rsp_route_cost,
   output logic                            rsp_reachable,
   output logic                            rsp_is_local,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dvrt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dvrt_pkg::CSR_DATA_W-1:0] csr_data
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_VNODE = 6'b000010,
      ST_VDEST = 6'b000100,
      ST_LINK  = 6'b001000,
      ST_QUERY = 6'b010000,
      ST_TICK  = 6'b100000
   } state_type;

   state_type                     state_ff, state_in;
   logic [dvrt_pkg::NODE_W-1:0]   node_ff, node_in;
   logic [dvrt_pkg::NODE_W-1:0]   dest_ff, dest_in;
   logic [dvrt_pkg::COST_W-1:0]   cost_ff, cost_in;
   logic [dvrt_pkg::NODE_W-1:0]   idx_ff, idx_in;
   logic [dvrt_pkg::COST_W-1:0]   ncost_ff, ncost_in;
   logic [dvrt_pkg::NODE_W-1:0]   nhop_ff, nhop_in;
   logic                          nvalid_ff, nvalid_in;
   logic [dvrt_pkg::NODE_W-1:0]   self_id_ff, self_id_in;
   logic [dvrt_pkg::MISS_W-1:0]   miss_limit_ff, miss_limit_in;
   dvrt_pkg::rsp_type             rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic [dvrt_pkg::NODE_W-1:0]   rd_idx;
   dvrt_pkg::entry_type           rd_ent;
   logic                          wr_en;
   logic [dvrt_pkg::NODE_W-1:0]   wr_idx;
   dvrt_pkg::entry_type           wr_ent;
   dvrt_pkg::entry_type           ent;
   dvrt_pkg::alu_res_type         alu_res;
   logic                          out_free;
   logic                          tick_last;

   dvrt_table u_table (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (rd_idx),
      .rd_ent (rd_ent),
      .wr_en  (wr_en),
      .wr_idx (wr_idx),
      .wr_ent (wr_ent)
   );

   // sender cost plus advertised cost against the destination's current cost
   dvrt_alu u_alu (
      .op_a     (ncost_ff),
      .op_b     (cost_ff),
      .op_limit (rd_ent.route_cost),
      .res      (alu_res)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign tick_last = (idx_ff == dvrt_pkg::NODE_W'(dvrt_pkg::NODES - 1));
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      self_id_in    = self_id_ff;
      miss_limit_in = miss_limit_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dvrt_pkg::CSR_SELF_ID:    self_id_in    = csr_data[dvrt_pkg::NODE_W-1:0];
            dvrt_pkg::CSR_MISS_LIMIT: miss_limit_in = csr_data[dvrt_pkg::MISS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      dest_in      = dest_ff;
      cost_in      = cost_ff;
      idx_in       = idx_ff;
      ncost_in     = ncost_ff;
      nhop_in      = nhop_ff;
      nvalid_in    = nvalid_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_idx       = node_ff;
      wr_en        = 1'b0;
      wr_idx       = node_ff;
      ent          = rd_ent;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               node_in = req_node;
               dest_in = req_dest;
               cost_in = req_cost;
               idx_in  = '0;
               unique case (dvrt_pkg::kind_type'(req_kind))
                  dvrt_pkg::KIND_VECTOR: begin
                     if (dvrt_pkg::in_range(req_node) && dvrt_pkg::in_range(req_dest)
                         && req_node != self_id_ff) begin
                        state_in = ST_VNODE;
                     end
                  end
                  dvrt_pkg::KIND_TICK: state_in = ST_TICK;
                  dvrt_pkg::KIND_LINK: begin
                     if (dvrt_pkg::in_range(req_node) && req_node != self_id_ff) begin
                        state_in = ST_LINK;
                     end
                  end
                  dvrt_pkg::KIND_QUERY: state_in = ST_QUERY;
                  default: ;
               endcase
            end
         end

         ST_VNODE: begin
            ent.heard = 1'b1;
            // sender was declared down: bring its direct link route back
            if (rd_ent.miss >= miss_limit_ff) begin
               ent.miss       = '0;
               ent.route_cost = rd_ent.link_cost;
               ent.hop        = node_ff;
               ent.hop_valid  = 1'b1;
            end
            wr_en     = 1'b1;
            ncost_in  = ent.route_cost;
            nhop_in   = ent.hop;
            nvalid_in = ent.hop_valid;
            state_in  = (dest_ff == self_id_ff) ? ST_IDLE : ST_VDEST;
         end

         ST_VDEST: begin
            rd_idx = dest_ff;
            wr_idx = dest_ff;
            if (alu_res.less) begin
               ent.route_cost = alu_res.sum;
               ent.hop        = nhop_ff;
               ent.hop_valid  = nvalid_ff;
               wr_en          = 1'b1;
            end
            state_in = ST_IDLE;
         end

         ST_LINK: begin
            ent.link_cost  = cost_ff;
            ent.neighbor   = 1'b1;
            ent.route_cost = cost_ff;
            ent.hop        = node_ff;
            ent.hop_valid  = 1'b1;
            wr_en          = 1'b1;
            state_in       = ST_IDLE;
         end

         ST_QUERY: begin
            if (out_free) begin
               rsp_in       = dvrt_pkg::emit(rd_ent, node_ff, self_id_ff, 1'b0);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_TICK: begin
            rd_idx = idx_ff;
            wr_idx = idx_ff;
            if (out_free) begin
               // dump the row first, then age it; later rows are untouched
               rsp_in       = dvrt_pkg::emit(rd_ent, idx_ff, self_id_ff, tick_last);
               rsp_valid_in = 1'b1;
               if (rd_ent.neighbor) begin
                  if (rd_ent.heard) begin
                     ent.miss = '0;
                  end else if (rd_ent.miss < dvrt_pkg::MISS_MAX) begin
                     ent.miss = rd_ent.miss + 1'b1;
                  end
                  if (ent.miss >= miss_limit_ff && idx_ff != self_id_ff) begin
                     ent.route_cost = dvrt_pkg::INF_COST;
                     ent.hop_valid  = 1'b0;
                  end
                  ent.heard = 1'b0;
                  wr_en     = 1'b1;
               end
               idx_in   = idx_ff + 1'b1;
               state_in = tick_last ? ST_IDLE : ST_TICK;
            end
         end

         default: state_in = ST_IDLE;
      endcase
      wr_ent = ent;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         self_id_ff    <= dvrt_pkg::SELF_ID_RESET;
         miss_limit_ff <= dvrt_pkg::MISS_LIMIT_RESET;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         self_id_ff    <= self_id_in;
         miss_limit_ff <= miss_limit_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff   <= node_in;
      dest_ff   <= dest_in;
      cost_ff   <= cost_in;
      ncost_ff  <= ncost_in;
      nhop_ff   <= nhop_in;
      nvalid_ff <= nvalid_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dest_node  = rsp_ff.dest_node;
   assign rsp_next_hop   = rsp_ff.next_hop;
   assign rsp_route_cost = rsp_ff.route_cost;
   assign rsp_reachable  = rsp_ff.reachable;
   assign rsp_is_local   = rsp_ff.is_local;
   assign rsp_last       = rsp_ff.last;

endmodule

@@ rtl/core/dvrt_checker.sv @@
// Port-level checker for the route table, bound to the top level.
module dvrt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [1:0]                      req_kind,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [dvrt_pkg::NODE_W-1:0]     rsp_dest_node,
   input logic [dvrt_pkg::NODE_W-1:0]     rsp_next_hop,
   input logic [dvrt_pkg::COST_W-1:0]     rsp_route_cost,
   input logic                            rsp_reachable,
   input logic                            rsp_is_local,
   input logic                            rsp_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dest_node)
                                  && $stable(rsp_route_cost) && $stable(rsp_last))
      else $error("stalled result changed");

   // own route is always cost zero and reachable
   a_local_route: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_local |-> rsp_reachable && rsp_route_cost == '0)
      else $error("local route not zero cost");

   // unreachable destinations report hop zero
   a_unreach_hop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reachable |-> rsp_next_hop == '0)
      else $error("unreachable route with nonzero hop");

   // the dump ends on the highest index
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_dest_node == dvrt_pkg::NODE_W'(dvrt_pkg::NODES - 1))
      else $error("dump ended on wrong index");

   // a tick keeps the block busy for the following cycle
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == dvrt_pkg::KIND_TICK |=> !req_ready)
      else $error("new request taken during tick dump");

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (.*);
